// ----- sv/smalu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smalu_pkg
// Shared types and constants for the sign-magnitude ALU.
// ----------------------------------------------------------------------------
package smalu_pkg;

    localparam int WORD_BITS = 16;
    localparam int CMD_BITS  = 4;

    typedef logic [CMD_BITS-1:0]  cmd_t;
    typedef logic [WORD_BITS-1:0] mag_t;

    localparam cmd_t CMD_AND  = 4'd0;
    localparam cmd_t CMD_OR   = 4'd1;
    localparam cmd_t CMD_XOR  = 4'd2;
    localparam cmd_t CMD_ADD  = 4'd3;
    localparam cmd_t CMD_SUB  = 4'd4;
    localparam cmd_t CMD_MUL  = 4'd5;
    localparam cmd_t CMD_DIV  = 4'd6;
    localparam cmd_t CMD_MOV  = 4'd7;
    localparam cmd_t CMD_NOT  = 4'd8;
    localparam cmd_t CMD_DEC  = 4'd9;
    localparam cmd_t CMD_INC  = 4'd10;
    localparam cmd_t CMD_ISGN = 4'd11;
    localparam cmd_t CMD_SSGN = 4'd12;

    // What travels along the divider chain with each beat.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
        logic a_sign;
        mag_t a_mag;
        logic b_sign;
        mag_t b_mag;
        mag_t rem;     // partial remainder
        mag_t quo;     // quotient bits so far, dividend bits shifted out
        logic res_sign;
        mag_t res_mag;
        logic dz;
    } slot_t;

endpackage

// ----- sv/sign_magnitude_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sign_magnitude_alu
// Sign-magnitude ALU with a pipelined divider built from a row of cells.
// ----------------------------------------------------------------------------
// A new beat is accepted every cycle while the output beat is not held.
// Every result takes the same path, whatever the opcode: the operands
// enter one register stage, then pass one division cell per quotient bit,
// then the output register. The whole pipe advances together and stalls
// only while the output beat is held. A sign of 1 means non-negative; a
// DIV by zero magnitude raises div_by_zero and returns A.
// ----------------------------------------------------------------------------
module sign_magnitude_alu (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [3:0]            s_cmd,
    input  logic                  s_a_sign,
    input  logic [15:0]           s_a_magnitude,
    input  logic                  s_b_sign,
    input  logic [15:0]           s_b_magnitude,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_res_sign,
    output logic [15:0]           m_res_magnitude,
    output logic                  m_div_by_zero
);

    localparam int W = smalu_pkg::WORD_BITS;

    smalu_pkg::slot_t chain [W+1];
    smalu_pkg::slot_t last;
    logic             en;
    logic             m_valid_reg;
    logic             res_sign_reg;
    smalu_pkg::mag_t  res_mag_reg;
    logic             dz_reg;
    smalu_pkg::slot_t front_slot;
    logic             front_valid_reg;

    // The pipe moves whenever the output register is free or being taken.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    smalu_front u_front (
        .aclk     (aclk),
        .en       (en),
        .in_valid (s_valid),
        .cmd      (s_cmd),
        .a_sign   (s_a_sign),
        .a_mag    (s_a_magnitude[W-1:0]),
        .b_sign   (s_b_sign),
        .b_mag    (s_b_magnitude[W-1:0]),
        .slot     (front_slot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (en) begin
            front_valid_reg <= s_valid;
        end
    end

    always_comb begin
        chain[0]       = front_slot;
        chain[0].valid = front_valid_reg;
    end

    for (genvar i = 0; i < W; i++) begin : g_cell
        smalu_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .slot_in  (chain[i]),
            .slot_out (chain[i+1])
        );
    end

    assign last = chain[W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dz_reg <= last.dz;
            if (last.cmd == smalu_pkg::CMD_DIV && !last.dz) begin
                res_mag_reg  <= last.quo;
                res_sign_reg <= (last.quo == '0) || (last.a_sign == last.b_sign);
            end else begin
                res_mag_reg  <= last.res_mag;
                res_sign_reg <= last.res_sign;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_res_sign      = res_sign_reg;
    assign m_res_magnitude = 16'(res_mag_reg);
    assign m_div_by_zero   = dz_reg;

endmodule

// ----- sv/smalu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smalu_front
// Combinational operations and the multiplier, registered together; loads the chain.
// ----------------------------------------------------------------------------
module smalu_front (
    input  logic                  aclk,
    input  logic                  en,
    input  logic                  in_valid,
    input  smalu_pkg::cmd_t       cmd,
    input  logic                  a_sign,
    input  smalu_pkg::mag_t       a_mag,
    input  logic                  b_sign,
    input  smalu_pkg::mag_t       b_mag,
    output smalu_pkg::slot_t      slot
);

    localparam int W = smalu_pkg::WORD_BITS;

    logic [W:0]        sum_mag;
    logic              sum_sign;
    logic              eff_b_sign;
    logic [2*W-1:0]    prod;
    smalu_pkg::slot_t  slot_next;

    always_comb begin
        eff_b_sign = (cmd == smalu_pkg::CMD_SUB) ? ~b_sign : b_sign;
        if (a_sign == eff_b_sign) begin
            sum_mag  = {1'b0, a_mag} + {1'b0, b_mag};
            sum_sign = a_sign;
        end else if (a_mag >= b_mag) begin
            sum_mag  = {1'b0, a_mag} - {1'b0, b_mag};
            sum_sign = a_sign;
        end else begin
            sum_mag  = {1'b0, b_mag} - {1'b0, a_mag};
            sum_sign = eff_b_sign;
        end
        // An exact zero is always non-negative.
        if (sum_mag == '0) begin
            sum_sign = 1'b1;
        end
        prod = a_mag * b_mag;
    end

    always_comb begin
        slot_next          = '0;
        slot_next.valid    = in_valid;
        slot_next.cmd      = cmd;
        slot_next.a_sign   = a_sign;
        slot_next.a_mag    = a_mag;
        slot_next.b_sign   = b_sign;
        slot_next.b_mag    = b_mag;
        slot_next.quo      = a_mag;
        slot_next.rem      = '0;
        slot_next.res_sign = a_sign;
        slot_next.res_mag  = a_mag;
        unique case (cmd)
            smalu_pkg::CMD_AND: begin
                slot_next.res_sign = a_sign & b_sign;
                slot_next.res_mag  = a_mag & b_mag;
            end
            smalu_pkg::CMD_OR: begin
                slot_next.res_sign = a_sign | b_sign;
                slot_next.res_mag  = a_mag | b_mag;
            end
            smalu_pkg::CMD_XOR: begin
                slot_next.res_sign = a_sign ^ b_sign;
                slot_next.res_mag  = a_mag ^ b_mag;
            end
            smalu_pkg::CMD_ADD, smalu_pkg::CMD_SUB: begin
                slot_next.res_sign = sum_sign;
                slot_next.res_mag  = sum_mag[W-1:0];
            end
            smalu_pkg::CMD_MUL: begin
                slot_next.res_sign = (a_mag == '0) || (b_mag == '0) || (a_sign == b_sign);
                slot_next.res_mag  = prod[W-1:0];
            end
            smalu_pkg::CMD_DIV: begin
                slot_next.dz = (b_mag == '0);
            end
            smalu_pkg::CMD_MOV: begin
                slot_next.res_sign = b_sign;
                slot_next.res_mag  = b_mag;
            end
            smalu_pkg::CMD_NOT: begin
                slot_next.res_sign = ~a_sign;
                slot_next.res_mag  = ~a_mag;
            end
            smalu_pkg::CMD_DEC: slot_next.res_mag = a_mag - smalu_pkg::mag_t'(1);
            smalu_pkg::CMD_INC: slot_next.res_mag = a_mag + smalu_pkg::mag_t'(1);
            smalu_pkg::CMD_ISGN: slot_next.res_sign = ~a_sign;
            smalu_pkg::CMD_SSGN: slot_next.res_sign = b_sign;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            slot <= slot_next;
        end
    end

endmodule

// ----- sv/smalu_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smalu_div_cell
// One restoring-division step; a row of these yields one quotient bit each.
// ----------------------------------------------------------------------------
module smalu_div_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  smalu_pkg::slot_t slot_in,
    output smalu_pkg::slot_t slot_out
);

    localparam int W = smalu_pkg::WORD_BITS;

    logic [W:0]       trial;
    logic [W:0]       diff;
    smalu_pkg::slot_t slot_next;
    smalu_pkg::slot_t slot_reg;

    always_comb begin
        slot_next = slot_in;
        trial     = {slot_in.rem, slot_in.quo[W-1]};
        diff      = trial - {1'b0, slot_in.b_mag};
        if (!diff[W]) begin
            slot_next.rem = diff[W-1:0];
            slot_next.quo = {slot_in.quo[W-2:0], 1'b1};
        end else begin
            slot_next.rem = trial[W-1:0];
            slot_next.quo = {slot_in.quo[W-2:0], 1'b0};
        end
    end

    // Only the valid bit needs a reset; the payload is ignored without it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else if (en) begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule

// ----- sv/smalu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smalu_checker
// Port-level checks on the sign-magnitude ALU, bound to the top level.
// ----------------------------------------------------------------------------
module smalu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_res_sign,
    input logic [15:0] m_res_magnitude,
    input logic        m_div_by_zero
);

    // A held result beat keeps its payload.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_magnitude)
        && $stable(m_res_sign) && $stable(m_div_by_zero))
        else $error("result beat changed while stalled");

    // Input is refused only while a result waits.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    // An offered input beat stays offered until it is taken.
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input beat withdrawn before acceptance");

    // A valid result beat carries a fully known payload.
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !$isunknown({m_res_sign, m_res_magnitude, m_div_by_zero}))
        else $error("result beat with unknown payload");

    // Nothing leaves straight after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat after reset");

endmodule

bind sign_magnitude_alu smalu_checker u_smalu_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_res_sign      (m_res_sign),
    .m_res_magnitude (m_res_magnitude),
    .m_div_by_zero   (m_div_by_zero)
);
